@@ design/pwmls_pkg.sv @@
// Shared constants and types for the PWM level shift-out driver.
// No dependencies; imported by pwm_level_shift_out_driver and its testbench.
package pwmls_pkg;

    // store geometry
    localparam int CHANNELS   = 24;
    localparam int LEVEL_BITS = 12;
    localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int BIT_W      = $clog2(LEVEL_BITS);

    // level constants
    localparam logic [15:0] LEVEL_MASK16 = 16'((32'd1 << LEVEL_BITS) - 32'd1);
    localparam logic [LEVEL_BITS-1:0] LEVEL_FULL  = LEVEL_BITS'(LEVEL_MASK16);
    localparam logic [LEVEL_BITS-1:0] RESET_LEVEL = LEVEL_BITS'(16'h0808 & LEVEL_MASK16);

    // configuration register reset values
    localparam logic [11:0] HIGH_THR_RESET = 12'd4000;
    localparam logic [11:0] LOW_THR_RESET  = 12'd150;

    // configuration register indexes
    localparam logic REG_HIGH_THR = 1'b0;
    localparam logic REG_LOW_THR  = 1'b1;

    // item commands
    typedef enum logic [1:0] {
        CMD_SET   = 2'd0,
        CMD_GET   = 2'd1,
        CMD_START = 2'd2,
        CMD_TICK  = 2'd3
    } cmd_t;

    // one stored level
    typedef logic [LEVEL_BITS-1:0] level_t;

endpackage

@@ design/pwm_level_shift_out_driver.sv @@
// Top level of the PWM level shift-out driver: level store, clamp,
// serializer sequencer and result register. Depends on pwmls_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one item: cmd, channel,
//   level_in. cmd selects set level, get level, start transfer or one tick.
//   Output channel (out_valid / out_stall) returns exactly one result item
//   per input item: read_level, the clock/data/latch pin levels after the
//   item, and busy_res.
//   An accepted item has its result in the output register after the edge
//   that accepts it; one item per cycle is taken unless the receiver stalls.
//   The path is a store read, a clamp compare and the sequencer step.
//   When the receiver stalls with a result waiting, in_stall goes high and
//   the block holds both the result and its state until the result is taken.
//   Each tick moves the serializer one half-bit, so a full transfer takes
//   2 * CHANNELS * LEVEL_BITS + 3 ticks after the start item.
//   Reset loads every stored level with 2056, the thresholds with 4000 and
//   150, puts the sequencer in idle with all pins low and empties the output
//   register. Write thresholds over the APB port only while idle (not enforced).
module pwm_level_shift_out_driver
    import pwmls_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // input item channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [7:0]  channel,
    input  logic [15:0] level_in,
    // result item channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [11:0] read_level,
    output logic        clock_out,
    output logic        data_out,
    output logic        latch_out,
    output logic        busy_res,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SHIFT_LO,
        PH_SHIFT_HI,
        PH_TAIL,
        PH_LATCH_HI,
        PH_LATCH_LO
    } phase_t;

    level_t                store_reg [CHANNELS];
    logic [11:0]           high_thr_reg;
    logic [11:0]           low_thr_reg;
    phase_t                phase_reg,  phase_next;
    logic [CH_W-1:0]       ch_idx_reg, ch_idx_next;
    logic [BIT_W-1:0]      bit_idx_reg, bit_idx_next;
    logic                  clk_pin_reg, clk_pin_next;
    logic                  dat_pin_reg, dat_pin_next;
    logic                  lat_pin_reg, lat_pin_next;
    logic                  out_valid_reg;
    logic [11:0]           read_level_reg, read_level_next;
    logic                  busy_reg;

    logic                  accept;
    logic                  busy;
    logic                  ch_ok;
    logic [CH_W-1:0]       ch_sel;
    logic [LEVEL_BITS-1:0] clamped;
    logic                  store_we;
    logic                  cfg_we;
    cmd_t                  cmd_in;

    // handshake
    assign in_stall  = out_valid_reg & out_stall;
    assign accept    = in_valid & ~in_stall;
    assign out_valid = out_valid_reg;

    // item decode
    assign cmd_in = cmd_t'(cmd);
    assign busy   = (phase_reg != PH_IDLE);
    assign ch_ok  = (channel != 8'd0) && ({1'b0, channel} <= 9'(CHANNELS));
    assign ch_sel = CH_W'(channel - 8'd1);

    // clamp of a requested level
    always_comb
    begin
        logic [15:0] lv;
        lv = level_in;
        if (lv > {4'd0, high_thr_reg})
        begin
            lv = LEVEL_MASK16;
        end
        if (lv < {4'd0, low_thr_reg})
        begin
            lv = 16'd0;
        end
        clamped = LEVEL_BITS'(lv & LEVEL_MASK16);
    end

    assign store_we = accept && (cmd_in == CMD_SET) && !busy && ch_ok;

    // sequencer and result next values
    always_comb
    begin
        phase_next      = phase_reg;
        ch_idx_next     = ch_idx_reg;
        bit_idx_next    = bit_idx_reg;
        clk_pin_next    = clk_pin_reg;
        dat_pin_next    = dat_pin_reg;
        lat_pin_next    = lat_pin_reg;
        read_level_next = 12'd0;
        case (cmd_in)
            CMD_GET:
            begin
                if (ch_ok)
                begin
                    read_level_next = 12'(store_reg[ch_sel]);
                end
            end
            CMD_START:
            begin
                if (!busy)
                begin
                    lat_pin_next = 1'b0;
                    ch_idx_next  = CH_W'(CHANNELS - 1);
                    bit_idx_next = BIT_W'(LEVEL_BITS - 1);
                    phase_next   = PH_SHIFT_LO;
                end
            end
            CMD_TICK:
            begin
                case (phase_reg)
                    PH_SHIFT_LO:
                    begin
                        clk_pin_next = 1'b0;
                        dat_pin_next = ~store_reg[ch_idx_reg][bit_idx_reg];
                        phase_next   = PH_SHIFT_HI;
                    end
                    PH_SHIFT_HI:
                    begin
                        clk_pin_next = 1'b1;
                        if (bit_idx_reg == '0)
                        begin
                            if (ch_idx_reg == '0)
                            begin
                                phase_next = PH_TAIL;
                            end
                            else
                            begin
                                ch_idx_next  = ch_idx_reg - CH_W'(1);
                                bit_idx_next = BIT_W'(LEVEL_BITS - 1);
                                phase_next   = PH_SHIFT_LO;
                            end
                        end
                        else
                        begin
                            bit_idx_next = bit_idx_reg - BIT_W'(1);
                            phase_next   = PH_SHIFT_LO;
                        end
                    end
                    PH_TAIL:
                    begin
                        clk_pin_next = 1'b0;
                        dat_pin_next = 1'b0;
                        phase_next   = PH_LATCH_HI;
                    end
                    PH_LATCH_HI:
                    begin
                        lat_pin_next = 1'b1;
                        phase_next   = PH_LATCH_LO;
                    end
                    PH_LATCH_LO:
                    begin
                        lat_pin_next = 1'b0;
                        phase_next   = PH_IDLE;
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
            default:
            begin
                // set only touches the store
            end
        endcase
    end

    // sequencer state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            ch_idx_reg    <= '0;
            bit_idx_reg   <= '0;
            clk_pin_reg   <= 1'b0;
            dat_pin_reg   <= 1'b0;
            lat_pin_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            busy_reg      <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg     <= phase_next;
                ch_idx_reg    <= ch_idx_next;
                bit_idx_reg   <= bit_idx_next;
                clk_pin_reg   <= clk_pin_next;
                dat_pin_reg   <= dat_pin_next;
                lat_pin_reg   <= lat_pin_next;
                busy_reg      <= (phase_next != PH_IDLE);
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // read level payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            read_level_reg <= read_level_next;
        end
    end

    // level store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                store_reg[i] <= RESET_LEVEL;
            end
        end
        else if (store_we)
        begin
            store_reg[ch_sel] <= clamped;
        end
    end

    // configuration registers
    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_thr_reg <= HIGH_THR_RESET;
            low_thr_reg  <= LOW_THR_RESET;
        end
        else if (cfg_we)
        begin
            if (paddr[2] == REG_HIGH_THR)
            begin
                high_thr_reg <= pwdata[11:0];
            end
            else
            begin
                low_thr_reg <= pwdata[11:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_HIGH_THR) ? {20'd0, high_thr_reg}
                                               : {20'd0, low_thr_reg};

    // result outputs
    assign read_level = read_level_reg;
    assign clock_out  = clk_pin_reg;
    assign data_out   = dat_pin_reg;
    assign latch_out  = lat_pin_reg;
    assign busy_res   = busy_reg;

`ifndef SYNTHESIS
    // clock and latch pins are never high together
    a_clk_lat_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(clk_pin_reg && lat_pin_reg))
        else $error("clock and latch high together");

    // busy flag in the result follows the sequencer
    a_busy_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (busy_reg == (phase_reg != PH_IDLE)))
        else $error("busy flag disagrees with sequencer");

    // bit index stays within one level while shifting
    a_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_SHIFT_LO || phase_reg == PH_SHIFT_HI)
            |-> ({1'b0, bit_idx_reg} < (BIT_W + 1)'(LEVEL_BITS)))
        else $error("bit index out of range");

    // store never changes during a transfer
    a_store_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !store_we)
        else $error("store written while busy");
`endif

endmodule

@@ test/pwm_level_shift_out_driver_test.sv @@
// Self-checking testbench for pwm_level_shift_out_driver: level store, clamp and serial transfer.
// Depends on pwmls_pkg and the design top; predicts every result item and compares it by field.
`timescale 1ns / 100ps

module pwm_level_shift_out_driver_test;
    import pwmls_pkg::*;

    localparam int TOTAL_BITS  = CHANNELS * LEVEL_BITS;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PRINT_LIMIT = 50;

    // serializer position of the predictor
    typedef enum {
        XFER_IDLE,
        XFER_BIT_LOW,
        XFER_BIT_HIGH,
        XFER_TAIL,
        XFER_LATCH_ON,
        XFER_LATCH_OFF
    } xfer_phase_t;

    // one predicted result item
    typedef struct {
        level_t level;
        logic   clk_pin;
        logic   dat_pin;
        logic   lat_pin;
        logic   busy;
    } pin_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  cmd = CMD_GET;
    logic [7:0]  channel = 8'd0;
    logic [15:0] level_in = 16'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [11:0] read_level;
    logic        clock_out;
    logic        data_out;
    logic        latch_out;
    logic        busy_res;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    // predictor state
    level_t      level_mem [CHANNELS];
    logic [11:0] thr_high;
    logic [11:0] thr_low;
    int          shift_pos;
    xfer_phase_t xfer;
    logic        pin_clk;
    logic        pin_dat;
    logic        pin_lat;

    pin_result_t pending_results [$];
    int          fail_count = 0;
    int          cycle_count = 0;
    int          burst_left = 0;
    int          stall_mode = 0;
    int          stall_count = 0;

    pwm_level_shift_out_driver dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .channel    (channel),
        .level_in   (level_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .read_level (read_level),
        .clock_out  (clock_out),
        .data_out   (data_out),
        .latch_out  (latch_out),
        .busy_res   (busy_res),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #2 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // receiver stall pattern, mode picked at random from four
    always @(posedge clk)
    begin
        stall_count <= stall_count + 1;
        if (stall_count % 97 == 0)
            stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 1) == 0);
            default: out_stall <= (stall_count % 8 < 3);
        endcase
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        if (fail_count < PRINT_LIMIT)
            $display("mismatch %s: got %0d expected %0d at cycle %0d",
                     what, got, want, cycle_count);
        fail_count++;
    endtask

    // compare each taken result item with the oldest prediction
    always @(posedge clk)
    begin : check_results
        pin_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result with nothing pending", 1, 0);
            else
            begin
                want = pending_results.pop_front();
                if (read_level !== want.level)
                    report_mismatch("read_level", int'(read_level), int'(want.level));
                if (clock_out !== want.clk_pin)
                    report_mismatch("clock_out", int'(clock_out), int'(want.clk_pin));
                if (data_out !== want.dat_pin)
                    report_mismatch("data_out", int'(data_out), int'(want.dat_pin));
                if (latch_out !== want.lat_pin)
                    report_mismatch("latch_out", int'(latch_out), int'(want.lat_pin));
                if (busy_res !== want.busy)
                    report_mismatch("busy_res", int'(busy_res), int'(want.busy));
            end
        end
    end

    task automatic reset_levels_model();
        foreach (level_mem[i])
            level_mem[i] = RESET_LEVEL;
        thr_high  = HIGH_THR_RESET;
        thr_low   = LOW_THR_RESET;
        shift_pos = 0;
        xfer      = XFER_IDLE;
        pin_clk   = 1'b0;
        pin_dat   = 1'b0;
        pin_lat   = 1'b0;
    endtask

    // serializer half-bit step
    task automatic advance_serializer();
        int slot;
        int bit_idx;
        case (xfer)
            XFER_BIT_LOW:
            begin
                slot    = CHANNELS - 1 - shift_pos / LEVEL_BITS;
                bit_idx = LEVEL_BITS - 1 - shift_pos % LEVEL_BITS;
                pin_clk = 1'b0;
                pin_dat = ~level_mem[slot][bit_idx];
                xfer    = XFER_BIT_HIGH;
            end
            XFER_BIT_HIGH:
            begin
                pin_clk = 1'b1;
                shift_pos++;
                xfer = (shift_pos >= TOTAL_BITS) ? XFER_TAIL : XFER_BIT_LOW;
            end
            XFER_TAIL:
            begin
                pin_clk = 1'b0;
                pin_dat = 1'b0;
                xfer    = XFER_LATCH_ON;
            end
            XFER_LATCH_ON:
            begin
                pin_lat = 1'b1;
                xfer    = XFER_LATCH_OFF;
            end
            XFER_LATCH_OFF:
            begin
                pin_lat   = 1'b0;
                xfer      = XFER_IDLE;
                shift_pos = 0;
            end
            default: xfer = XFER_IDLE;
        endcase
    endtask

    // predict the result of one accepted item and queue it
    task automatic predict_item(input cmd_t c, input logic [7:0] ch, input logic [15:0] lv);
        pin_result_t res;
        logic        was_busy;
        logic        ch_ok;
        logic [15:0] clamped;
        was_busy  = (xfer != XFER_IDLE);
        ch_ok     = (ch >= 8'd1) && (int'(ch) <= CHANNELS);
        res.level = '0;
        case (c)
            CMD_SET:
                if (!was_busy && ch_ok)
                begin
                    clamped = lv;
                    if (clamped > 16'(thr_high))
                        clamped = 16'(LEVEL_FULL);
                    if (clamped < 16'(thr_low))
                        clamped = 16'd0;
                    level_mem[int'(ch) - 1] = clamped[LEVEL_BITS-1:0];
                end
            CMD_GET:
                if (ch_ok)
                    res.level = level_mem[int'(ch) - 1];
            CMD_START:
                if (!was_busy)
                begin
                    pin_lat   = 1'b0;
                    shift_pos = 0;
                    xfer      = XFER_BIT_LOW;
                end
            default:
                if (was_busy)
                    advance_serializer();
        endcase
        res.clk_pin = pin_clk;
        res.dat_pin = pin_dat;
        res.lat_pin = pin_lat;
        res.busy    = (xfer != XFER_IDLE);
        pending_results.push_back(res);
    endtask

    // send one item; valid stays high within a burst
    task automatic send_item(input cmd_t c, input logic [7:0] ch, input logic [15:0] lv);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 100)
                                                     : $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        cmd      <= c;
        channel  <= ch;
        level_in <= lv;
        do
            @(posedge clk);
        while (in_stall);
        predict_item(c, ch, lv);
    endtask

    // stop sending and wait for every pending result
    task automatic drain_results();
        in_valid   <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_threshold(input logic idx, input logic [11:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= 32'(val);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_HIGH_THR)
            thr_high = val;
        else
            thr_low = val;
    endtask

    function automatic logic [7:0] pick_channel();
        if ($urandom_range(0, 4) == 0)
            return 8'($urandom_range(0, 255));
        return 8'($urandom_range(1, CHANNELS));
    endfunction

    // levels around the thresholds, in range, or anywhere in 16 bits
    function automatic logic [15:0] pick_level();
        case ($urandom_range(0, 5))
            0: return 16'(int'(thr_high) + $urandom_range(0, 2) - 1);
            1: return 16'(int'(thr_low) + $urandom_range(0, 2) - 1);
            2: return 16'($urandom_range(0, 4095));
            3: return ($urandom_range(0, 1) == 0) ? 16'd0 : 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_random_item(input int w_set, input int w_get, input int w_start);
        int   roll;
        cmd_t c;
        roll = $urandom_range(0, 99);
        if (roll < w_set)
            c = CMD_SET;
        else if (roll < w_set + w_get)
            c = CMD_GET;
        else if (roll < w_set + w_get + w_start)
            c = CMD_START;
        else
            c = CMD_TICK;
        send_item(c, pick_channel(), pick_level());
    endtask

    // reset contents, bad channels, clamp edges at reset thresholds, idle tick
    task automatic test_reset_and_clamp();
        send_item(CMD_GET, 8'd1, 16'd0);
        send_item(CMD_GET, 8'd24, 16'hffff);
        send_item(CMD_GET, 8'd0, 16'd0);
        send_item(CMD_GET, 8'd25, 16'd0);
        send_item(CMD_GET, 8'd255, 16'd0);
        send_item(CMD_TICK, 8'd3, 16'h5a5a);
        send_item(CMD_SET, 8'd1, 16'd0);
        send_item(CMD_SET, 8'd24, 16'hffff);
        send_item(CMD_SET, 8'd2, 16'd4000);
        send_item(CMD_SET, 8'd3, 16'd4001);
        send_item(CMD_SET, 8'd4, 16'd150);
        send_item(CMD_SET, 8'd5, 16'd149);
        send_item(CMD_SET, 8'd0, 16'd100);
        send_item(CMD_SET, 8'd25, 16'd200);
        send_item(CMD_SET, 8'd255, 16'd300);
        for (int ch = 1; ch <= 5; ch++)
            send_item(CMD_GET, 8'(ch), 16'd0);
        send_item(CMD_GET, 8'd24, 16'd0);
        drain_results();
    endtask

    // one complete transfer with busy-time items mixed in
    task automatic test_full_transfer();
        for (int ch = 1; ch <= CHANNELS; ch++)
            send_item(CMD_SET, 8'(ch), 16'($urandom_range(0, 4095)));
        send_item(CMD_START, pick_channel(), pick_level());
        send_item(CMD_SET, 8'd5, 16'h0abc);
        send_item(CMD_START, 8'd1, 16'd0);
        send_item(CMD_GET, 8'd24, 16'd0);
        while (xfer != XFER_IDLE)
        begin
            if ($urandom_range(0, 6) == 0)
                send_random_item(30, 40, 10);
            else
                send_item(CMD_TICK, 8'($urandom), 16'($urandom));
        end
        send_item(CMD_TICK, 8'd7, 16'd0);
        send_item(CMD_GET, 8'd5, 16'd0);
        drain_results();
    endtask

    // extreme and random threshold settings, sets and gets around them
    task automatic test_thresholds();
        logic [11:0] hi_vals [4];
        logic [11:0] lo_vals [4];
        hi_vals = '{12'd4095, 12'd0, 12'($urandom), 12'hfff ^ 12'($urandom)};
        lo_vals = '{12'd0, 12'd4095, 12'($urandom), 12'($urandom)};
        for (int s = 0; s < 4; s++)
        begin
            write_threshold(REG_HIGH_THR, hi_vals[s]);
            write_threshold(REG_LOW_THR, lo_vals[s]);
            repeat (30)
                send_random_item(55, 45, 0);
            drain_results();
        end
    endtask

    // random mix, transfers may start and end anywhere
    task automatic test_random_mix();
        write_threshold(REG_HIGH_THR, 12'($urandom_range(2048, 4095)));
        write_threshold(REG_LOW_THR, 12'($urandom_range(0, 2047)));
        repeat (130)
        begin
            if (xfer != XFER_IDLE)
                send_random_item(10, 15, 5);
            else
                send_random_item(35, 30, 10);
        end
        drain_results();
    endtask

    initial
    begin
        reset_levels_model();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_and_clamp();
        test_full_transfer();
        test_thresholds();
        test_random_mix();
        if (pending_results.size() != 0)
            report_mismatch("results never arrived", 0, pending_results.size());
        repeat (4) @(posedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
